@@ sv/wsf_pkg.sv @@
// Shared types, constants and helpers for the word stream filter.
package wsf_pkg;

  localparam int WSF_SET_BYTES    = 8;
  localparam int WSF_MAX_WORD_LEN = 255;

  localparam int WSF_BYTE_W     = 8;
  localparam int WSF_LEN_W      = 9;
  localparam int WSF_OUT_DATA_W = 16;
  localparam int WSF_CFG_DATA_W = 64;
  localparam int WSF_CFG_ADDR_W = 6;
  localparam int WSF_REG_IDX_W  = 3;

  localparam logic [7:0] WSF_WILDCARD      = 8'h23;
  localparam logic [7:0] WSF_DEFAULT_DELIM = 8'h0A;

  localparam int WSF_EN_LENGTH  = 0;
  localparam int WSF_EN_COMPOSE = 1;

  typedef enum logic [WSF_REG_IDX_W-1:0] {
    REG_DELIMITER      = 3'd0,
    REG_FILTER_ENABLES = 3'd1,
    REG_LENGTH_TARGET  = 3'd2,
    REG_INCLUDE_SET    = 3'd3,
    REG_COMPOSE_SET    = 3'd4,
    REG_PATTERN_MASK   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic [1:0]  filter_enables;
    logic [7:0]  length_target;
    logic [63:0] include_set;
    logic [63:0] compose_set;
    logic [63:0] pattern_mask;
  } wsf_cfg_t;

  typedef struct packed {
    logic                 is_delim;
    logic                 word_pass;
    logic [WSF_LEN_W-1:0] word_length;
  } wsf_res_t;

  function automatic logic [7:0] wsf_slot(input logic [63:0] packed_w, input int k);
    return packed_w[8*k +: 8];
  endfunction

endpackage

@@ sv/word_stream_filter.sv @@
// A delimiter passes the input register, then the result register, which drives out_*.
// Every byte passes the input register and the check logic; a new one enters as the last leaves.
// A delimiter waits in the input register only while the result register holds an untaken result.
// Reset (synchronous, rst_n low): configuration registers take their defaults, delimiter newline,
// the running word checks clear and both channels empty.
module word_stream_filter import wsf_pkg::*; #(
  parameter int SET_BYTES    = WSF_SET_BYTES,
  parameter int MAX_WORD_LEN = WSF_MAX_WORD_LEN
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [WSF_BYTE_W-1:0]     in_tdata,     // [7:0] data_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [WSF_OUT_DATA_W-1:0] out_tdata,    // [8:0] word_length, [15:9] zero
  output logic                      out_tuser,    // [0] word_pass
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [WSF_CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [WSF_CFG_DATA_W-1:0] cfg_pwdata,
  output logic [WSF_CFG_DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  wsf_cfg_t cfg;
  wsf_res_t res;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [WSF_BYTE_W-1:0] s1_byte_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_pass_r;
  logic [WSF_LEN_W-1:0]  out_len_r;
  logic                  out_free;
  logic                  s1_go;
  logic                  load_out;

  wsf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wsf_word_check #(
    .SET_BYTES    (SET_BYTES),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (s1_go),
    .byte_in (s1_byte_r),
    .res     (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!res.is_delim || out_free);
  assign load_out  = s1_go && res.is_delim;
  assign in_tready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (load_out) begin
      out_pass_r <= res.word_pass;
      out_len_r  <= res.word_length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = WSF_OUT_DATA_W'(out_len_r);
  assign out_tuser  = out_pass_r;

endmodule

@@ sv/wsf_regs.sv @@
// APB-style configuration register file for the word stream filter.
module wsf_regs import wsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [WSF_CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [WSF_CFG_DATA_W-1:0] cfg_pwdata,
  output logic [WSF_CFG_DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output wsf_cfg_t                  cfg
);

  wsf_cfg_t cfg_r;
  wsf_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[WSF_CFG_ADDR_W-1:3]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DELIMITER:      cfg_nxt.delimiter      = cfg_pwdata[7:0];
        REG_FILTER_ENABLES: cfg_nxt.filter_enables = cfg_pwdata[1:0];
        REG_LENGTH_TARGET:  cfg_nxt.length_target  = cfg_pwdata[7:0];
        REG_INCLUDE_SET:    cfg_nxt.include_set    = cfg_pwdata;
        REG_COMPOSE_SET:    cfg_nxt.compose_set    = cfg_pwdata;
        REG_PATTERN_MASK:   cfg_nxt.pattern_mask   = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELIMITER:      cfg_prdata = WSF_CFG_DATA_W'(cfg_r.delimiter);
      REG_FILTER_ENABLES: cfg_prdata = WSF_CFG_DATA_W'(cfg_r.filter_enables);
      REG_LENGTH_TARGET:  cfg_prdata = WSF_CFG_DATA_W'(cfg_r.length_target);
      REG_INCLUDE_SET:    cfg_prdata = cfg_r.include_set;
      REG_COMPOSE_SET:    cfg_prdata = cfg_r.compose_set;
      REG_PATTERN_MASK:   cfg_prdata = cfg_r.pattern_mask;
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter     <= WSF_DEFAULT_DELIM;
      cfg_r.filter_enables <= '0;
      cfg_r.length_target <= '0;
      cfg_r.include_set   <= '0;
      cfg_r.compose_set   <= '0;
      cfg_r.pattern_mask  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/wsf_word_check.sv @@
// Per-word running checks and the verdict produced when the delimiter arrives.
module wsf_word_check import wsf_pkg::*; #(
  parameter int SET_BYTES    = WSF_SET_BYTES,
  parameter int MAX_WORD_LEN = WSF_MAX_WORD_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsf_cfg_t              cfg,
  input  logic                  step,
  input  logic [WSF_BYTE_W-1:0] byte_in,
  output wsf_res_t              res
);

  localparam int LW = $clog2(MAX_WORD_LEN + 2);
  localparam int PW = $clog2(SET_BYTES + 1);
  localparam int CW = (LW > 8) ? LW : 8;

  logic [LW-1:0]        len_r, len_nxt;
  logic [SET_BYTES-1:0] seen_r, seen_nxt;
  logic                 allowed_r, allowed_nxt;
  logic                 prefix_r, prefix_nxt;

  logic [PW-1:0]        plen;
  logic                 plen_run;
  logic [7:0]           pat_byte;
  logic [SET_BYTES-1:0] req_used;
  logic [SET_BYTES-1:0] req_hit;
  logic                 any_allowed;
  logic                 in_pattern;
  logic                 len_sat;
  logic                 is_delim;
  logic                 len_bad, req_bad, set_bad, pat_bad;

  // Pattern length is the number of nonzero slots before the first zero.
  always_comb begin
    plen     = '0;
    plen_run = 1'b1;
    pat_byte = '0;
    for (int k = 0; k < SET_BYTES; k++) begin
      if (plen_run && wsf_slot(cfg.pattern_mask, k) != 8'd0) begin
        plen = plen + PW'(1);
      end else begin
        plen_run = 1'b0;
      end
      if (len_r == LW'(k)) begin
        pat_byte = wsf_slot(cfg.pattern_mask, k);
      end
    end
  end

  always_comb begin
    any_allowed = 1'b0;
    for (int k = 0; k < SET_BYTES; k++) begin
      req_used[k] = wsf_slot(cfg.include_set, k) != 8'd0;
      req_hit[k]  = req_used[k] && (wsf_slot(cfg.include_set, k) == byte_in);
      if (wsf_slot(cfg.compose_set, k) != 8'd0 && wsf_slot(cfg.compose_set, k) == byte_in) begin
        any_allowed = 1'b1;
      end
    end
  end

  assign in_pattern = {{PW{1'b0}}, len_r} < {{LW{1'b0}}, plen};
  assign len_sat    = len_r > LW'(MAX_WORD_LEN);
  assign is_delim   = byte_in == cfg.delimiter;

  assign len_bad = cfg.filter_enables[WSF_EN_LENGTH] &&
                   (len_sat || CW'(len_r) != CW'(cfg.length_target));
  assign req_bad = |(req_used & ~seen_r);
  assign set_bad = cfg.filter_enables[WSF_EN_COMPOSE] && !allowed_r;
  assign pat_bad = !prefix_r || in_pattern;

  assign res.is_delim    = is_delim;
  assign res.word_pass   = !(len_bad || req_bad || set_bad || pat_bad);
  assign res.word_length = WSF_LEN_W'(len_r);

  always_comb begin
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    allowed_nxt = allowed_r;
    prefix_nxt  = prefix_r;
    if (step) begin
      if (is_delim) begin
        len_nxt     = '0;
        seen_nxt    = '0;
        allowed_nxt = 1'b1;
        prefix_nxt  = 1'b1;
      end else begin
        seen_nxt    = seen_r | req_hit;
        allowed_nxt = allowed_r && any_allowed;
        if (in_pattern && pat_byte != WSF_WILDCARD && pat_byte != byte_in) begin
          prefix_nxt = 1'b0;
        end
        if (!len_sat) begin
          len_nxt = len_r + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      seen_r    <= '0;
      allowed_r <= 1'b1;
      prefix_r  <= 1'b1;
    end else begin
      len_r     <= len_nxt;
      seen_r    <= seen_nxt;
      allowed_r <= allowed_nxt;
      prefix_r  <= prefix_nxt;
    end
  end

endmodule

@@ sv/wsf_checker.sv @@
// Port-level checks for the word stream filter and their bind to the top level.
module wsf_checker import wsf_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [WSF_OUT_DATA_W-1:0] out_tdata,
  input logic                      out_tuser
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // With room for a result, the input side never stalls.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled although the result register is free");

  // Reset empties the result channel.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Once reset has released, an empty pipeline accepts a byte.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind word_stream_filter wsf_checker u_wsf_checker (.*);
